@@ design/dsh_pkg.sv @@
package dsh_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE_MS      = 3'd0;
    localparam logic [2:0] REG_HOLD_DELAY_MS    = 3'd1;
    localparam logic [2:0] REG_HOLD_INTERVAL_MS = 3'd2;
    localparam logic [2:0] REG_BUTTON_TYPE      = 3'd3;
    localparam logic [2:0] REG_LED_POLARITY     = 3'd4;
    localparam logic [2:0] REG_HOLD_LISTENER    = 3'd5;

    // button types
    localparam logic [1:0] BTN_PULLDOWN      = 2'd0;
    localparam logic [1:0] BTN_PULLUP        = 2'd1;
    localparam logic [1:0] BTN_INT_PULLUP    = 2'd2;

    // reset values of the registers
    localparam logic [31:0] RST_DEBOUNCE_MS      = 32'd50;
    localparam logic [31:0] RST_HOLD_DELAY_MS    = 32'd0;
    localparam logic [31:0] RST_HOLD_INTERVAL_MS = 32'd0;
    localparam logic [1:0]  RST_BUTTON_TYPE      = BTN_PULLUP;
    localparam logic        RST_LED_POLARITY     = 1'b0;
    localparam logic        RST_HOLD_LISTENER    = 1'b1;

    typedef struct packed {
        logic [31:0] debounce_ms;
        logic [31:0] hold_delay_ms;
        logic [31:0] hold_interval_ms;
        logic [1:0]  button_type;
        logic        led_polarity;
        logic        hold_listener;
    } t_cfg;

    // a write of the button type forces both level registers to the idle level
    typedef struct packed {
        logic wr;
        logic idle;
    } t_type_upd;

    typedef struct packed {
        logic        pressed;
        logic        just_pressed;
        logic        just_released;
        logic        click;
        logic        hold;
        logic [31:0] down_time;
        logic        led_drive;
        logic        pull_up_enable;
    } t_result;

    // pin level that means the switch is pressed
    function automatic logic pressed_level(input logic [1:0] btype);
        return (btype == BTN_PULLDOWN);
    endfunction

endpackage

@@ design/dsh_cfg.sv @@
module dsh_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [2:0]           i_index,
    input  logic [31:0]          i_data,
    output dsh_pkg::t_cfg        o_cfg,
    output dsh_pkg::t_type_upd   o_type_upd
);

    dsh_pkg::t_cfg r_cfg;
    dsh_pkg::t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        o_type_upd.wr = 1'b0;
        o_type_upd.idle = ~dsh_pkg::pressed_level(i_data[1:0]);
        if (i_wr) begin
            case (i_index)
                dsh_pkg::REG_DEBOUNCE_MS:      n_cfg.debounce_ms = i_data;
                dsh_pkg::REG_HOLD_DELAY_MS:    n_cfg.hold_delay_ms = i_data;
                dsh_pkg::REG_HOLD_INTERVAL_MS: n_cfg.hold_interval_ms = i_data;
                dsh_pkg::REG_BUTTON_TYPE: begin
                    n_cfg.button_type = i_data[1:0];
                    o_type_upd.wr = 1'b1;
                end
                dsh_pkg::REG_LED_POLARITY:     n_cfg.led_polarity = i_data[0];
                dsh_pkg::REG_HOLD_LISTENER:    n_cfg.hold_listener = i_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= dsh_pkg::RST_DEBOUNCE_MS;
            r_cfg.hold_delay_ms    <= dsh_pkg::RST_HOLD_DELAY_MS;
            r_cfg.hold_interval_ms <= dsh_pkg::RST_HOLD_INTERVAL_MS;
            r_cfg.button_type      <= dsh_pkg::RST_BUTTON_TYPE;
            r_cfg.led_polarity     <= dsh_pkg::RST_LED_POLARITY;
            r_cfg.hold_listener    <= dsh_pkg::RST_HOLD_LISTENER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/dsh_step.sv @@
module dsh_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_sample,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_led_on,
    input  dsh_pkg::t_cfg        i_cfg,
    input  dsh_pkg::t_type_upd   i_type_upd,
    output dsh_pkg::t_result     o_result
);

    logic        r_last_raw;
    logic        r_stable;
    logic [31:0] r_db_start;
    logic [31:0] r_hold_sent;
    logic [31:0] r_held;

    logic        n_last_raw;
    logic        n_stable;
    logic [31:0] n_db_start;
    logic [31:0] n_hold_sent;
    logic [31:0] n_held;

    logic        plev;
    logic [31:0] elapsed;
    logic [31:0] held_calc;
    logic        settled;
    logic        edge_det;
    logic        click;
    logic        hold;
    logic        hold_due;

    // debounce, edge and hold decisions for the word in the input register
    always_comb begin
        plev        = dsh_pkg::pressed_level(i_cfg.button_type);
        n_db_start  = (i_sample != r_last_raw) ? i_now_ms : r_db_start;
        elapsed     = i_now_ms - n_db_start;
        held_calc   = elapsed - i_cfg.debounce_ms;
        settled     = elapsed > i_cfg.debounce_ms;
        n_stable    = r_stable;
        n_hold_sent = r_hold_sent;
        n_held      = r_held;
        n_last_raw  = i_sample;
        edge_det    = 1'b0;
        click       = 1'b0;
        hold        = 1'b0;
        hold_due    = (r_hold_sent == 32'd0) ||
                      ((i_cfg.hold_interval_ms != 32'd0) &&
                       ((i_now_ms - r_hold_sent) > i_cfg.hold_interval_ms));
        if (settled) begin
            if (r_stable != i_sample) begin
                n_stable    = i_sample;
                edge_det    = 1'b1;
                n_hold_sent = 32'd0;
                if (i_sample != plev) begin
                    click = (r_held < i_cfg.hold_delay_ms) || !i_cfg.hold_listener;
                end
            end else if (r_stable == plev) begin
                n_held = held_calc;
                if ((i_cfg.hold_delay_ms != 32'd0) && hold_due &&
                    (held_calc > i_cfg.hold_delay_ms) && i_cfg.hold_listener) begin
                    hold        = 1'b1;
                    n_hold_sent = i_now_ms;
                end
            end
        end
    end

    // result word
    always_comb begin
        o_result.pressed        = (n_stable == plev);
        o_result.just_pressed   = edge_det & (n_stable == plev);
        o_result.just_released  = edge_det & (n_stable != plev);
        o_result.click          = click;
        o_result.hold           = hold;
        o_result.down_time      = n_held;
        o_result.led_drive      = i_cfg.led_polarity ^ i_led_on;
        o_result.pull_up_enable = (i_cfg.button_type == dsh_pkg::BTN_INT_PULLUP);
    end

    // switch state, type write takes precedence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= ~dsh_pkg::pressed_level(dsh_pkg::RST_BUTTON_TYPE);
            r_stable    <= ~dsh_pkg::pressed_level(dsh_pkg::RST_BUTTON_TYPE);
            r_db_start  <= 32'd0;
            r_hold_sent <= 32'd0;
            r_held      <= 32'd0;
        end else if (i_type_upd.wr) begin
            r_last_raw <= i_type_upd.idle;
            r_stable   <= i_type_upd.idle;
        end else if (i_adv) begin
            r_last_raw  <= n_last_raw;
            r_stable    <= n_stable;
            r_db_start  <= n_db_start;
            r_hold_sent <= n_hold_sent;
            r_held      <= n_held;
        end
    end

endmodule

@@ design/debounced_switch_hold_events_top.sv @@
// Debounced switch with press, release, click and hold events.
// Input channel (i_in_valid / o_in_ready) carries one sample word per tick:
// raw pin level, millisecond timestamp and LED request. Output channel
// (o_out_valid / i_out_ready) returns exactly one result word per sample.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes one register per
// word by index: 0 debounce, 1 hold delay, 2 hold interval, 3 button type,
// 4 LED polarity, 5 hold listener; other indexes are dropped. Write it only
// while no sample is in flight.
// The accepting edge loads a sample into the input register; the debounce and
// hold result then loads into the result register once that register is free
// or drained. Throughput is one word per cycle while the receiver does not
// stall, set by a single pass of subtract and compare logic.
// When the receiver stalls, the result register holds and the input register
// keeps the next word, so o_in_ready drops only when both are full.
// Synchronous reset empties both registers, restores the register defaults
// and sets the switch state to released for a pull-up button.
module debounced_switch_hold_events_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_sample,
    input  logic [31:0] i_now_ms,
    input  logic        i_led_on,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_pressed,
    output logic        o_just_pressed,
    output logic        o_just_released,
    output logic        o_click,
    output logic        o_hold,
    output logic [31:0] o_down_time,
    output logic        o_led_drive,
    output logic        o_pull_up_enable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    dsh_pkg::t_cfg      cfg;
    dsh_pkg::t_type_upd type_upd;
    dsh_pkg::t_result   step_res;

    logic               r_in_valid;
    logic               r_sample;
    logic [31:0]        r_now_ms;
    logic               r_led_on;
    logic               r_out_valid;
    dsh_pkg::t_result   r_res;
    logic               adv;

    // handshake: word moves on when the result register is free or drained
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    dsh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_cfg      (cfg),
        .o_type_upd (type_upd)
    );

    dsh_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_sample   (r_sample),
        .i_now_ms   (r_now_ms),
        .i_led_on   (r_led_on),
        .i_cfg      (cfg),
        .i_type_upd (type_upd),
        .o_result   (step_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sample <= i_sample;
            r_now_ms <= i_now_ms;
            r_led_on <= i_led_on;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pressed        = r_res.pressed;
    assign o_just_pressed   = r_res.just_pressed;
    assign o_just_released  = r_res.just_released;
    assign o_click          = r_res.click;
    assign o_hold           = r_res.hold;
    assign o_down_time      = r_res.down_time;
    assign o_led_drive      = r_res.led_drive;
    assign o_pull_up_enable = r_res.pull_up_enable;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dsh_pkg::*;

    // register indexes with no register behind them, and the spare button type
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam logic [1:0] BTN_SPARE   = 2'd3;

    localparam int N_PHASES        = 10;
    localparam int WORDS_PER_PHASE = 125;
    localparam int LATENCY_PAUSE   = 4;
    localparam int BIG_STALL_AT    = 600;
    localparam int BIG_STALL_LEN   = 80;
    localparam int MAX_REPORTS     = 40;

    typedef enum logic [0:0] {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        logic        smp;
        logic [31:0] now;
        logic        led;
        logic        known;
        t_result     want;
    } t_plan_row;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // block ports
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_sample    = 1'b0;
    logic [31:0] i_now_ms    = '0;
    logic        i_led_on    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_pressed;
    logic        o_just_pressed;
    logic        o_just_released;
    logic        o_click;
    logic        o_hold;
    logic [31:0] o_down_time;
    logic        o_led_drive;
    logic        o_pull_up_enable;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    debounced_switch_hold_events_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .i_now_ms         (i_now_ms),
        .i_led_on         (i_led_on),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pressed        (o_pressed),
        .o_just_pressed   (o_just_pressed),
        .o_just_released  (o_just_released),
        .o_click          (o_click),
        .o_hold           (o_hold),
        .o_down_time      (o_down_time),
        .o_led_drive      (o_led_drive),
        .o_pull_up_enable (o_pull_up_enable),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // predictor copy of the registers
    logic [31:0] cf_debounce;
    logic [31:0] cf_hold_delay;
    logic [31:0] cf_hold_ivl;
    logic [1:0]  cf_btn_type;
    logic        cf_led_pol;
    logic        cf_listener;

    // predictor copy of the switch state
    logic        sw_last_raw;
    logic        sw_stable;
    logic [31:0] sw_db_start;
    logic [31:0] sw_hold_sent;
    logic [31:0] sw_held;

    t_result   results_due[$];
    t_plan_row plan_rows[$];
    int        n_words_in = 0;
    int        n_mismatch = 0;

    // word in flight on the input side, with a typed-in result where there is one
    logic      cur_known = 1'b0;
    t_result   cur_known_result = '0;
    logic      tx_steady = 1'b0;

    // register write as the block sees it
    function automatic void cfg_apply(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_DEBOUNCE_MS:      cf_debounce   = data;
            REG_HOLD_DELAY_MS:    cf_hold_delay = data;
            REG_HOLD_INTERVAL_MS: cf_hold_ivl   = data;
            REG_BUTTON_TYPE: begin
                cf_btn_type = data[1:0];
                // both levels go to the released level of the new type
                sw_last_raw = (data[1:0] != BTN_PULLDOWN);
                sw_stable   = (data[1:0] != BTN_PULLDOWN);
            end
            REG_LED_POLARITY:     cf_led_pol  = data[0];
            REG_HOLD_LISTENER:    cf_listener = data[0];
            default: ;
        endcase
    endfunction

    // one sample through debounce, edge, click and hold logic
    function automatic t_result debounce_step(input logic smp, input logic [31:0] now,
                                              input logic led);
        t_result     res;
        logic        press_lvl;
        logic        flip;
        logic [31:0] elapsed;
        logic [31:0] since_hold;
        res       = '0;
        flip      = 1'b0;
        press_lvl = (cf_btn_type == BTN_PULLDOWN);
        // any raw change restarts the debounce timer
        if (smp != sw_last_raw)
            sw_db_start = now;
        elapsed = now - sw_db_start;
        if (elapsed > cf_debounce) begin
            if (sw_stable != smp) begin
                sw_stable    = smp;
                flip         = 1'b1;
                sw_hold_sent = '0;
                // click on release uses the stored down time
                if (sw_stable != press_lvl)
                    res.click = (sw_held < cf_hold_delay) || !cf_listener;
            end else if (sw_stable == press_lvl) begin
                sw_held    = elapsed - cf_debounce;
                since_hold = now - sw_hold_sent;
                // a hold sent at time zero reads back as not sent
                if (cf_hold_delay != '0 &&
                    (sw_hold_sent == '0 || (cf_hold_ivl != '0 && since_hold > cf_hold_ivl)) &&
                    sw_held > cf_hold_delay && cf_listener) begin
                    res.hold     = 1'b1;
                    sw_hold_sent = now;
                end
            end
        end
        sw_last_raw        = smp;
        res.pressed        = (sw_stable == press_lvl);
        res.just_pressed   = flip && res.pressed;
        res.just_released  = flip && !res.pressed;
        res.down_time      = sw_held;
        res.led_drive      = cf_led_pol ^ led;
        res.pull_up_enable = (cf_btn_type == BTN_INT_PULLUP);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
            $display("mismatch on %s at %0t: got %0h, want %0h", field, $realtime, got, want);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    // handshakes seen at the rising edge: check results, track writes, predict
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cf_debounce   = RST_DEBOUNCE_MS;
            cf_hold_delay = RST_HOLD_DELAY_MS;
            cf_hold_ivl   = RST_HOLD_INTERVAL_MS;
            cf_btn_type   = RST_BUTTON_TYPE;
            cf_led_pol    = RST_LED_POLARITY;
            cf_listener   = RST_HOLD_LISTENER;
            sw_last_raw   = (RST_BUTTON_TYPE != BTN_PULLDOWN);
            sw_stable     = (RST_BUTTON_TYPE != BTN_PULLDOWN);
            sw_db_start   = '0;
            sw_hold_sent  = '0;
            sw_held       = '0;
            results_due.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_pressed, o_just_pressed, o_just_released, o_click, o_hold,
                       o_down_time, o_led_drive, o_pull_up_enable};
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected word", got.down_time, '0);
                end else begin
                    want = results_due.pop_front();
                    if (got.pressed !== want.pressed)
                        report_mismatch("pressed", 32'(got.pressed), 32'(want.pressed));
                    if (got.just_pressed !== want.just_pressed)
                        report_mismatch("just_pressed", 32'(got.just_pressed),
                                        32'(want.just_pressed));
                    if (got.just_released !== want.just_released)
                        report_mismatch("just_released", 32'(got.just_released),
                                        32'(want.just_released));
                    if (got.click !== want.click)
                        report_mismatch("click", 32'(got.click), 32'(want.click));
                    if (got.hold !== want.hold)
                        report_mismatch("hold", 32'(got.hold), 32'(want.hold));
                    if (got.down_time !== want.down_time)
                        report_mismatch("down_time", got.down_time, want.down_time);
                    if (got.led_drive !== want.led_drive)
                        report_mismatch("led_drive", 32'(got.led_drive), 32'(want.led_drive));
                    if (got.pull_up_enable !== want.pull_up_enable)
                        report_mismatch("pull_up_enable", 32'(got.pull_up_enable),
                                        32'(want.pull_up_enable));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                cfg_apply(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                want = debounce_step(i_sample, i_now_ms, i_led_on);
                if (cur_known)
                    want = cur_known_result;
                results_due.push_back(want);
                n_words_in++;
            end
        end
    end

    // receiver: random stalls, quiet stretches and one long hold-off
    initial begin : receiver
        int   stall_left;
        int   mode_left;
        logic steady;
        logic big_done;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        big_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = 150;
            end
            mode_left--;
            if (!big_done && n_words_in >= BIG_STALL_AT) begin
                stall_left = BIG_STALL_LEN;
                big_done   = 1'b1;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    function automatic void plan_word(input logic smp, input logic [31:0] now,
                                      input logic led, input logic known = 1'b0,
                                      input t_result want = '0);
        t_plan_row row;
        row       = '0;
        row.kind  = ROW_WORD;
        row.smp   = smp;
        row.now   = now;
        row.led   = led;
        row.known = known;
        row.want  = want;
        plan_rows.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [2:0] idx, input logic [31:0] data);
        t_plan_row row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = data;
        plan_rows.push_back(row);
    endfunction

    // offer one word after a random gap, or none when steady, and wait for it to be taken
    task automatic send_word(input logic smp, input logic [31:0] now, input logic led,
                             input logic known, input t_result want);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_sample         <= smp;
        i_now_ms         <= now;
        i_led_on         <= led;
        cur_known        = known;
        cur_known_result = want;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready))
            @(posedge i_clk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready))
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus and end of run
    initial begin : stimulus
        t_result     led_only;
        logic [31:0] now;
        logic [31:0] dbn;
        logic [31:0] hdly;
        logic [31:0] hivl;
        logic [1:0]  btype;
        logic        level;
        logic        smp;
        int          run_left;
        int          step_max;

        led_only           = '0;
        led_only.led_drive = 1'b1;

        // directed rows: reset state, extremes, press and release, holds, clicks
        plan_word(1'b1, 32'd0, 1'b0, 1'b1, '0);
        plan_word(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, led_only);
        plan_reg(REG_DEBOUNCE_MS, 32'd2);
        plan_reg(REG_HOLD_DELAY_MS, 32'd5);
        plan_reg(REG_HOLD_INTERVAL_MS, 32'd3);
        // press, first hold, repeated hold, long release without click
        plan_word(1'b0, 32'd100, 1'b0);
        plan_word(1'b0, 32'd103, 1'b1);
        plan_word(1'b0, 32'd110, 1'b0);
        plan_word(1'b0, 32'd114, 1'b1);
        plan_word(1'b1, 32'd120, 1'b0);
        plan_word(1'b1, 32'd123, 1'b0);
        // short press gives a click
        plan_word(1'b0, 32'd200, 1'b0);
        plan_word(1'b0, 32'd203, 1'b0);
        plan_word(1'b0, 32'd204, 1'b0);
        plan_word(1'b1, 32'd210, 1'b0);
        plan_word(1'b1, 32'd213, 1'b0);
        // hold raised at timestamp zero counts as not sent, so it fires again
        plan_word(1'b0, 32'hFFFF_FFF0, 1'b0);
        plan_word(1'b0, 32'hFFFF_FFF3, 1'b0);
        plan_word(1'b0, 32'd0, 1'b0);
        plan_word(1'b0, 32'd1, 1'b0);
        plan_word(1'b1, 32'd10, 1'b0);
        plan_word(1'b1, 32'd13, 1'b0);
        // spare button type acts as pull-up, no listener means click on release
        plan_reg(REG_BUTTON_TYPE, {30'd0, BTN_SPARE});
        plan_reg(REG_HOLD_LISTENER, 32'd0);
        plan_reg(REG_LED_POLARITY, 32'd1);
        plan_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        plan_word(1'b0, 32'd20, 1'b1);
        plan_word(1'b0, 32'd23, 1'b1);
        plan_word(1'b1, 32'd30, 1'b0);
        plan_word(1'b1, 32'd33, 1'b0);
        // pull-down button pressed high, then internal pull-up
        plan_reg(REG_BUTTON_TYPE, {30'd0, BTN_PULLDOWN});
        plan_word(1'b1, 32'd40, 1'b0);
        plan_word(1'b1, 32'd43, 1'b0);
        plan_reg(REG_BUTTON_TYPE, {30'd0, BTN_INT_PULLUP});
        plan_word(1'b0, 32'd50, 1'b1);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[i]) begin
            if (plan_rows[i].kind == ROW_REG)
                write_reg(plan_rows[i].idx, plan_rows[i].data);
            else
                send_word(plan_rows[i].smp, plan_rows[i].now, plan_rows[i].led,
                          plan_rows[i].known, plan_rows[i].want);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                dbn   = '0;
                hdly  = 32'd1;
                hivl  = '0;
                btype = BTN_PULLDOWN;
            end else if (p == 1) begin
                dbn   = 32'hFFFF_FFFF;
                hdly  = 32'hFFFF_FFFF;
                hivl  = 32'hFFFF_FFFF;
                btype = BTN_INT_PULLUP;
            end else begin
                dbn   = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 12);
                hdly  = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 30);
                hivl  = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 10);
                btype = 2'($urandom_range(0, 3));
            end
            write_reg(REG_DEBOUNCE_MS, dbn);
            write_reg(REG_HOLD_DELAY_MS, hdly);
            write_reg(REG_HOLD_INTERVAL_MS, hivl);
            write_reg(REG_BUTTON_TYPE, ($urandom() & 32'hFFFF_FFFC) | {30'd0, btype});
            write_reg(REG_LED_POLARITY, $urandom());
            write_reg(REG_HOLD_LISTENER, (p < 2) ? 32'd1 : $urandom());
            if (p % 3 == 2)
                write_reg(REG_SPARE_7, $urandom());

            tx_steady = (p % 4 == 3);
            now       = (p == 2) ? 32'hFFFF_FF00 : $urandom();
            level     = 1'($urandom_range(0, 1));
            run_left  = 0;
            step_max  = $urandom_range(1, 4);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // runs of one level with occasional bounce
                if (run_left == 0) begin
                    level    = ~level;
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                smp = ($urandom_range(0, 9) == 0) ? ~level : level;
                if ($urandom_range(0, 99) == 0)
                    now = $urandom();
                else
                    now = now + $urandom_range(0, step_max);
                send_word(smp, now, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end

        wait_drained();
        if (n_mismatch == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
